// ----- src/btpc_pkg.sv -----
// ============================================================================
// btpc_pkg
// Types and constants shared by the barometer compensation core.
// ============================================================================
package btpc_pkg;

    typedef struct packed {
        logic [15:0] raw_temperature;
        logic [23:0] raw_pressure_bytes;
    } btpc_in_t;

    typedef struct packed {
        logic signed [15:0] temperature_tenths;
        logic [19:0]        pressure_pascal;
        logic               status;
    } btpc_out_t;

    typedef enum logic [2:0] {
        CFG_AC1     = 3'd0,
        CFG_AC2     = 3'd1,
        CFG_AC3     = 3'd2,
        CFG_AC4     = 3'd3,
        CFG_AC5_AC6 = 3'd4,
        CFG_B1_B2   = 3'd5,
        CFG_MC_MD   = 3'd6,
        CFG_OSS     = 3'd7
    } cfg_reg_e;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [15:0] RST_AC1     = 16'd408;
    localparam logic [15:0] RST_AC2     = 16'hFFB8;
    localparam logic [15:0] RST_AC3     = 16'hC7D1;
    localparam logic [15:0] RST_AC4     = 16'd32741;
    localparam logic [31:0] RST_AC5_AC6 = 32'd2146785905;
    localparam logic [31:0] RST_B1_B2   = 32'd405667844;
    localparam logic [31:0] RST_MC_MD   = 32'd3724086068;
    localparam logic [1:0]  RST_OSS     = 2'd0;

    localparam logic signed [29:0] B6_OFFSET   = 30'sd4000;
    localparam logic signed [31:0] B4_BIAS     = 32'sd32768;
    localparam logic [15:0]        B7_SCALE    = 16'd50000;
    localparam logic signed [13:0] P_LIN_COEF  = -14'sd7357;
    localparam logic signed [12:0] P_SQ_COEF   = 13'sd3038;
    localparam logic signed [17:0] P_OFFSET    = 18'sd3791;
    localparam logic [31:0]        P_MAX       = 32'd1048575;

    // pipelined divider sizes
    localparam int TD_N = 27;   // temperature quotient bits
    localparam int TD_D = 18;   // temperature divisor bits
    localparam int PD_N = 32;   // pressure quotient bits
    localparam int PD_D = 17;   // pressure divisor bits

endpackage

// ----- src/barometer_temp_pressure_compensation_core.sv -----
// ============================================================================
// barometer_temp_pressure_compensation_core
// Integer temperature and pressure compensation of barometric sensor readings.
// ============================================================================
// Fully pipelined: one transaction enters per clock while s_ready is high.
// The pipe is built around two restoring dividers, one quotient bit per stage
// (27 stages for the temperature term, 32 for pressure), plus the multiply
// stages around them. Backpressure stalls the whole pipe only once the
// two-entry output buffer is full. Configuration is written through the cfg
// port (always ready) and must only change while the pipe is empty.
module barometer_temp_pressure_compensation_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  btpc_pkg::btpc_in_t           s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output btpc_pkg::btpc_out_t          m_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [btpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [btpc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import btpc_pkg::*;

    localparam int NST = 73;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [15:0] cal_ac1_reg, cal_ac2_reg, cal_ac3_reg, cal_ac4_reg;
    logic [31:0] cal_ac5_ac6_reg, cal_b1_b2_reg, cal_mc_md_reg;
    logic [1:0]  oss_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_ac1_reg     <= RST_AC1;
            cal_ac2_reg     <= RST_AC2;
            cal_ac3_reg     <= RST_AC3;
            cal_ac4_reg     <= RST_AC4;
            cal_ac5_ac6_reg <= RST_AC5_AC6;
            cal_b1_b2_reg   <= RST_B1_B2;
            cal_mc_md_reg   <= RST_MC_MD;
            oss_reg         <= RST_OSS;
        end else if (cfg_valid) begin
            case (cfg_reg_e'(cfg_index))
                CFG_AC1:     cal_ac1_reg     <= cfg_data[15:0];
                CFG_AC2:     cal_ac2_reg     <= cfg_data[15:0];
                CFG_AC3:     cal_ac3_reg     <= cfg_data[15:0];
                CFG_AC4:     cal_ac4_reg     <= cfg_data[15:0];
                CFG_AC5_AC6: cal_ac5_ac6_reg <= cfg_data;
                CFG_B1_B2:   cal_b1_b2_reg   <= cfg_data;
                CFG_MC_MD:   cal_mc_md_reg   <= cfg_data;
                CFG_OSS:     oss_reg         <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic [15:0]        ac4, ac5, ac6;

    assign ac1 = $signed(cal_ac1_reg);
    assign ac2 = $signed(cal_ac2_reg);
    assign ac3 = $signed(cal_ac3_reg);
    assign ac4 = cal_ac4_reg;
    assign ac5 = cal_ac5_ac6_reg[31:16];
    assign ac6 = cal_ac5_ac6_reg[15:0];
    assign b1  = $signed(cal_b1_b2_reg[31:16]);
    assign b2  = $signed(cal_b1_b2_reg[15:0]);
    assign mc  = $signed(cal_mc_md_reg[31:16]);
    assign md  = $signed(cal_mc_md_reg[15:0]);

    // ------------------------------------------------------------------
    // pipeline control
    // ------------------------------------------------------------------
    logic            en;
    logic [NST-1:0]  vld_reg;
    btpc_out_t       out_reg, skid_reg, fin_reg;
    logic            out_valid_reg, skid_valid_reg;

    assign en      = !skid_valid_reg;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-2:0], s_valid};
        end
    end

    // ------------------------------------------------------------------
    // stage 1: raw operands
    // ------------------------------------------------------------------
    logic [3:0]         sh1;
    logic [23:0]        upsh1;
    logic signed [16:0] diff1_reg, diff1_next;
    logic [18:0]        up1_reg;

    assign sh1        = 4'd8 - {2'b00, oss_reg};
    assign upsh1      = s_data.raw_pressure_bytes >> sh1;
    assign diff1_next = $signed({1'b0, s_data.raw_temperature}) - $signed({1'b0, ac6});

    // stage 2: (ut - ac6) * ac5
    logic signed [33:0] prod2;
    logic [31:0]        p2_reg;
    logic [18:0]        up2_reg;

    assign prod2 = diff1_reg * $signed({1'b0, ac5});

    // stage 3 (temperature divider entry)
    logic signed [16:0] x1_3;
    logic signed [17:0] den3;
    logic [15:0]        mc_abs;
    logic [17:0]        den_abs;

    assign x1_3    = $signed(p2_reg[31:15]);
    assign den3    = $signed({x1_3[16], x1_3}) + $signed({{2{md[15]}}, md});
    assign mc_abs  = mc[15] ? 16'(-mc) : mc;
    assign den_abs = den3[17] ? 18'(-den3) : den3;

    logic [TD_D-1:0]    t_rem_reg [0:TD_N];
    logic [TD_N-1:0]    t_q_reg   [0:TD_N];
    logic [TD_D-1:0]    t_dsr_reg [0:TD_N];
    logic signed [16:0] t_x1_reg  [0:TD_N];
    logic [18:0]        t_up_reg  [0:TD_N];
    logic               t_neg_reg [0:TD_N];
    logic               t_dz_reg  [0:TD_N];

    always_ff @(posedge aclk) begin
        if (en) begin
            diff1_reg    <= diff1_next;
            up1_reg      <= upsh1[18:0];
            p2_reg       <= prod2[31:0];
            up2_reg      <= up1_reg;
            t_rem_reg[0] <= '0;
            t_q_reg[0]   <= {mc_abs, 11'b0};
            t_dsr_reg[0] <= den_abs;
            t_x1_reg[0]  <= x1_3;
            t_up_reg[0]  <= up2_reg;
            t_neg_reg[0] <= mc[15] ^ den3[17];
            t_dz_reg[0]  <= (den3 == '0);
        end
    end

    for (genvar j = 0; j < TD_N; j++) begin : g_tdiv
        logic [TD_D:0] rs, dif;
        logic          ge;
        assign rs  = {t_rem_reg[j], t_q_reg[j][TD_N-1]};
        assign dif = rs - {1'b0, t_dsr_reg[j]};
        assign ge  = rs >= {1'b0, t_dsr_reg[j]};
        always_ff @(posedge aclk) begin
            if (en) begin
                t_rem_reg[j+1] <= ge ? dif[TD_D-1:0] : rs[TD_D-1:0];
                t_q_reg[j+1]   <= {t_q_reg[j][TD_N-2:0], ge};
                t_dsr_reg[j+1] <= t_dsr_reg[j];
                t_x1_reg[j+1]  <= t_x1_reg[j];
                t_up_reg[j+1]  <= t_up_reg[j];
                t_neg_reg[j+1] <= t_neg_reg[j];
                t_dz_reg[j+1]  <= t_dz_reg[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 4: b5, temperature, b6
    // ------------------------------------------------------------------
    logic signed [27:0] x2_4, qs_4;
    logic signed [28:0] b5_4;
    logic signed [29:0] b5r_4, tsh_4, b6_next;
    logic signed [15:0] t_next;

    assign qs_4    = $signed({1'b0, t_q_reg[TD_N]});
    assign x2_4    = t_neg_reg[TD_N] ? -qs_4 : qs_4;
    assign b5_4    = x2_4 + t_x1_reg[TD_N];
    assign b5r_4   = b5_4 + 30'sd8;
    assign tsh_4   = b5r_4 >>> 4;
    assign b6_next = b5_4 - B6_OFFSET;

    always_comb begin
        if (tsh_4 > 30'sd32767) begin
            t_next = 16'sh7FFF;
        end else if (tsh_4 < -30'sd32768) begin
            t_next = 16'sh8000;
        end else begin
            t_next = tsh_4[15:0];
        end
    end

    logic signed [29:0] b6_reg;
    logic signed [15:0] t4_reg, t5_reg, t6_reg, t7_reg, t8_reg, t9_reg;
    logic [18:0]        up4_reg, up5_reg, up6_reg, up7_reg, up8_reg, up9_reg;
    logic               e4_reg, e5_reg, e6_reg, e7_reg, e8_reg, e9_reg;

    // stage 5: products of b6
    logic signed [59:0] sqw5;
    logic signed [45:0] a2w5, a3w5;
    logic [31:0]        sqw_reg, a2w_reg, a3w_reg;

    assign sqw5 = b6_reg * b6_reg;
    assign a2w5 = ac2 * b6_reg;
    assign a3w5 = ac3 * b6_reg;

    // stage 6: shifted terms
    logic signed [19:0] sq_reg;
    logic signed [20:0] x2a_reg, x2a7_reg;
    logic signed [18:0] x1c_reg, x1c7_reg;

    // stage 7: b2 * sq, b1 * sq
    logic signed [35:0] mb2_7, mb1_7;
    logic [31:0]        mb2_reg, mb1_reg;

    assign mb2_7 = b2 * sq_reg;
    assign mb1_7 = b1 * sq_reg;

    // stage 8: x3 sums
    logic signed [20:0] x1b_8;
    logic signed [21:0] x3a_next, x3a_reg;
    logic signed [15:0] x2c_8;
    logic signed [19:0] s8, x3p_8;
    logic signed [31:0] x3p32_8, xs_next;
    logic [31:0]        xs_reg;

    assign x1b_8    = $signed(mb2_reg[31:11]);
    assign x3a_next = x1b_8 + x2a7_reg;
    assign x2c_8    = $signed(mb1_reg[31:16]);
    assign s8       = x1c7_reg + x2c_8 + 20'sd2;
    assign x3p_8    = s8 >>> 2;
    assign x3p32_8  = x3p_8;
    assign xs_next  = x3p32_8 + B4_BIAS;

    // stage 9: b3 and b4
    logic signed [22:0] b3a_9;
    logic signed [25:0] b3e_9, b3s_9;
    logic signed [26:0] b3p_9;
    logic [47:0]        b4w_9;
    logic signed [24:0] b3_reg;
    logic [PD_D-1:0]    b4_reg;

    assign b3a_9 = $signed({ac1, 2'b00}) + x3a_reg;
    assign b3e_9 = b3a_9;
    assign b3s_9 = b3e_9 <<< oss_reg;
    assign b3p_9 = b3s_9 + 27'sd2;
    assign b4w_9 = ac4 * xs_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            b6_reg   <= b6_next;
            t4_reg   <= t_next;
            up4_reg  <= t_up_reg[TD_N];
            e4_reg   <= t_dz_reg[TD_N];

            sqw_reg  <= sqw5[31:0];
            a2w_reg  <= a2w5[31:0];
            a3w_reg  <= a3w5[31:0];
            t5_reg   <= t4_reg;
            up5_reg  <= up4_reg;
            e5_reg   <= e4_reg;

            sq_reg   <= $signed(sqw_reg[31:12]);
            x2a_reg  <= $signed(a2w_reg[31:11]);
            x1c_reg  <= $signed(a3w_reg[31:13]);
            t6_reg   <= t5_reg;
            up6_reg  <= up5_reg;
            e6_reg   <= e5_reg;

            mb2_reg  <= mb2_7[31:0];
            mb1_reg  <= mb1_7[31:0];
            x2a7_reg <= x2a_reg;
            x1c7_reg <= x1c_reg;
            t7_reg   <= t6_reg;
            up7_reg  <= up6_reg;
            e7_reg   <= e6_reg;

            x3a_reg  <= x3a_next;
            xs_reg   <= xs_next;
            t8_reg   <= t7_reg;
            up8_reg  <= up7_reg;
            e8_reg   <= e7_reg;

            b3_reg   <= b3p_9[26:2];
            b4_reg   <= b4w_9[31:15];
            t9_reg   <= t8_reg;
            up9_reg  <= up8_reg;
            e9_reg   <= e8_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 10: b7 and pressure divider entry
    // ------------------------------------------------------------------
    logic signed [31:0] b3_32;
    logic [31:0]        diffp_10, b7_10;
    logic [15:0]        k_10;
    logic [47:0]        b7w_10;

    assign b3_32    = b3_reg;
    assign diffp_10 = {13'b0, up9_reg} - b3_32;
    assign k_10     = B7_SCALE >> oss_reg;
    assign b7w_10   = diffp_10 * k_10;
    assign b7_10    = b7w_10[31:0];

    logic [PD_D-1:0]    p_rem_reg [0:PD_N];
    logic [PD_N-1:0]    p_q_reg   [0:PD_N];
    logic [PD_D-1:0]    p_dsr_reg [0:PD_N];
    logic signed [15:0] p_t_reg   [0:PD_N];
    logic               p_hi_reg  [0:PD_N];
    logic               p_err_reg [0:PD_N];

    always_ff @(posedge aclk) begin
        if (en) begin
            p_rem_reg[0] <= '0;
            p_q_reg[0]   <= b7_10[31] ? b7_10 : {b7_10[30:0], 1'b0};
            p_dsr_reg[0] <= b4_reg;
            p_t_reg[0]   <= t9_reg;
            p_hi_reg[0]  <= b7_10[31];
            p_err_reg[0] <= e9_reg || (b4_reg == '0);
        end
    end

    for (genvar j = 0; j < PD_N; j++) begin : g_pdiv
        logic [PD_D:0] rs, dif;
        logic          ge;
        assign rs  = {p_rem_reg[j], p_q_reg[j][PD_N-1]};
        assign dif = rs - {1'b0, p_dsr_reg[j]};
        assign ge  = rs >= {1'b0, p_dsr_reg[j]};
        always_ff @(posedge aclk) begin
            if (en) begin
                p_rem_reg[j+1] <= ge ? dif[PD_D-1:0] : rs[PD_D-1:0];
                p_q_reg[j+1]   <= {p_q_reg[j][PD_N-2:0], ge};
                p_dsr_reg[j+1] <= p_dsr_reg[j];
                p_t_reg[j+1]   <= p_t_reg[j];
                p_hi_reg[j+1]  <= p_hi_reg[j];
                p_err_reg[j+1] <= p_err_reg[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // stages 11..14: final pressure correction
    // ------------------------------------------------------------------
    logic [31:0]        pu_11;
    logic signed [31:0] p11_reg, p12_reg, p13_reg;
    logic signed [23:0] pp_reg;
    logic signed [15:0] t11_reg, t12_reg, t13_reg;
    logic               e11_reg, e12_reg, e13_reg;

    assign pu_11 = p_hi_reg[PD_N] ? {p_q_reg[PD_N][30:0], 1'b0} : p_q_reg[PD_N];

    logic signed [47:0] sqp_12;
    logic signed [45:0] m2_12;
    logic signed [31:0] sqp_reg, m2_reg;

    assign sqp_12 = pp_reg * pp_reg;
    assign m2_12  = p11_reg * P_LIN_COEF;

    logic signed [44:0] y1_13;
    logic signed [31:0] y1_reg;
    logic signed [15:0] x2_reg;

    assign y1_13 = sqp_reg * P_SQ_COEF;

    logic signed [15:0] x1_14;
    logic signed [17:0] s_14;
    logic signed [13:0] sh_14;
    logic signed [31:0] sh32_14, pf_14;
    btpc_out_t          fin_next;

    assign x1_14   = y1_reg[31:16];
    assign s_14    = x1_14 + x2_reg + P_OFFSET;
    assign sh_14   = s_14[17:4];
    assign sh32_14 = sh_14;
    assign pf_14   = p13_reg + sh32_14;

    always_comb begin
        fin_next.temperature_tenths = t13_reg;
        fin_next.status             = 1'b0;
        if (pf_14[31]) begin
            fin_next.pressure_pascal = '0;
        end else if ($unsigned(pf_14) > P_MAX) begin
            fin_next.pressure_pascal = P_MAX[19:0];
        end else begin
            fin_next.pressure_pascal = pf_14[19:0];
        end
        if (e13_reg) begin
            fin_next.temperature_tenths = '0;
            fin_next.pressure_pascal    = '0;
            fin_next.status             = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p11_reg <= $signed(pu_11);
            pp_reg  <= $signed(pu_11[31:8]);
            t11_reg <= p_t_reg[PD_N];
            e11_reg <= p_err_reg[PD_N];

            sqp_reg <= sqp_12[31:0];
            m2_reg  <= m2_12[31:0];
            p12_reg <= p11_reg;
            t12_reg <= t11_reg;
            e12_reg <= e11_reg;

            y1_reg  <= y1_13[31:0];
            x2_reg  <= m2_reg[31:16];
            p13_reg <= p12_reg;
            t13_reg <= t12_reg;
            e13_reg <= e12_reg;

            fin_reg <= fin_next;
        end
    end

    // ------------------------------------------------------------------
    // output register with skid entry
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= vld_reg[NST-1];
            end
        end else if (vld_reg[NST-1] && en) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            out_reg <= skid_valid_reg ? skid_reg : fin_reg;
        end else if (en) begin
            skid_reg <= fin_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds data while output register is empty");

    a_skid_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_ready))
        else $error("skid entry filled without an output stall");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status) |->
            (m_data.temperature_tenths == '0 && m_data.pressure_pascal == '0))
        else $error("error transaction carries nonzero results");

    a_tail_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (!en && vld_reg[NST-1]) |=> vld_reg[NST-1])
        else $error("pipeline tail lost a transaction during stall");
`endif

endmodule
